// File: src/m4i_pkg.sv
package m4i_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// Register index as decoded from paddr[2].
	localparam logic REG_EMIT_TRANSPOSED = 1'b0;

	typedef enum logic [3:0] {
		S_LOAD,
		S_RD_A,
		S_RD_B,
		S_RD_C,
		S_MAC,
		S_COF_WR,
		S_DET,
		S_DIV_RD,
		S_DIV_INIT,
		S_DIV,
		S_DIV_OUT
	} state_t;

	typedef enum logic [1:0] {
		MC_ELEM,
		MC_MINOR,
		MC_COF
	} mc_sel_t;

	typedef struct packed {
		logic       load_we;
		logic [3:0] load_addr;
		logic [3:0] elem_raddr;
		logic [3:0] cof_raddr;
		logic       cof_we;
		logic [3:0] cof_waddr;
		logic       mc_load;
		mc_sel_t    mc_sel;
		logic       mp_load;
		logic       mac_step;
		logic       mac_last;
		logic       mac_neg;
		logic       mac_dest_acc;
		logic       minor_clr;
		logic       acc_clr;
		logic       det_load;
		logic       div_start;
		logic       div_step;
		logic       out_load;
		logic       out_last;
	} cmd_t;

	typedef struct packed {
		logic det_zero;
		logic out_full;
	} status_t;

	// Index of the pos-th row or column of a 3x3 minor that leaves out skip.
	function automatic logic [1:0] skip_idx(input logic [1:0] skip, input logic [1:0] pos);
		skip_idx = (pos < skip) ? pos : pos + 2'd1;
	endfunction

endpackage

// File: src/m4i_in_if.sv
interface m4i_in_if #(parameter int W = m4i_pkg::DATA_WIDTH) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] element_value;

	modport source(output valid, output element_value, input ready);
	modport sink(input valid, input element_value, output ready);
endinterface

// File: src/m4i_out_if.sv
interface m4i_out_if #(parameter int W = m4i_pkg::DATA_WIDTH) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] result_value;
	logic                is_singular;
	logic                is_last;

	modport source(output valid, output result_value, output is_singular, output is_last,
		input ready);
	modport sink(input valid, input result_value, input is_singular, input is_last,
		output ready);
endinterface

// File: src/m4i_ram.sv
module m4i_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rd_data_q
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_data_q <= mem_q[raddr];
	end
endmodule

// File: src/m4i_ctrl.sv
module m4i_ctrl #(
	parameter int W = m4i_pkg::DATA_WIDTH,
	parameter int F = m4i_pkg::FRAC_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             emit_transposed,
	input  m4i_pkg::status_t status,
	output m4i_pkg::cmd_t    cmd
);
	localparam int AW    = 4 * W + 2;
	localparam int NB    = AW + 2 * F;
	localparam int CNT_W = $clog2(NB);

	m4i_pkg::state_t state_q, state_d;
	logic [3:0]       load_cnt_q, load_cnt_d;
	logic [3:0]       idx_q, idx_d;
	logic [1:0]       term_q, term_d;
	logic [1:0]       ph_q, ph_d;
	logic             det_mode_q, det_mode_d;
	logic [CNT_W-1:0] bit_q, bit_d;

	logic [1:0] row, col, sr0, sr1, sr2, cp, cq, ck;
	logic [3:0] mc_addr, mp_addr, src_addr;
	logic       mac_last, div_last, div_phase;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= m4i_pkg::S_LOAD;
			load_cnt_q <= '0;
			idx_q      <= '0;
			term_q     <= '0;
			ph_q       <= '0;
			det_mode_q <= 1'b0;
			bit_q      <= '0;
		end else begin
			state_q    <= state_d;
			load_cnt_q <= load_cnt_d;
			idx_q      <= idx_d;
			term_q     <= term_d;
			ph_q       <= ph_d;
			det_mode_q <= det_mode_d;
			bit_q      <= bit_d;
		end
	end

	// Element addresses of the current cofactor term.
	always_comb begin
		row = idx_q[3:2];
		col = idx_q[1:0];
		sr0 = m4i_pkg::skip_idx(row, 2'd0);
		sr1 = m4i_pkg::skip_idx(row, 2'd1);
		sr2 = m4i_pkg::skip_idx(row, 2'd2);
		cp  = m4i_pkg::skip_idx(col, (term_q == 2'd0) ? 2'd1 : 2'd0);
		cq  = m4i_pkg::skip_idx(col, (term_q == 2'd2) ? 2'd1 : 2'd2);
		ck  = m4i_pkg::skip_idx(col, term_q);
		case (ph_q)
			2'd0: begin
				mc_addr = {sr1, cp};
				mp_addr = {sr2, cq};
			end
			2'd1: begin
				mc_addr = {sr1, cq};
				mp_addr = {sr2, cp};
			end
			default: begin
				mc_addr = '0;
				mp_addr = {sr0, ck};
			end
		endcase
		if (det_mode_q) begin
			mp_addr = {2'd0, idx_q[1:0]};
		end
		src_addr = emit_transposed ? idx_q : {idx_q[1:0], idx_q[3:2]};
	end

	assign mac_last  = (bit_q == CNT_W'(W - 1));
	assign div_last  = (bit_q == CNT_W'(NB - 1));
	assign div_phase = (state_q == m4i_pkg::S_DIV_RD) || (state_q == m4i_pkg::S_DIV_INIT) ||
		(state_q == m4i_pkg::S_DIV) || (state_q == m4i_pkg::S_DIV_OUT);

	always_comb begin
		state_d    = state_q;
		load_cnt_d = load_cnt_q;
		idx_d      = idx_q;
		term_d     = term_q;
		ph_d       = ph_q;
		det_mode_d = det_mode_q;
		bit_d      = bit_q;
		cmd        = '0;

		// The next matrix may load while this one divides, all but its last element.
		in_ready = (state_q == m4i_pkg::S_LOAD) || (div_phase && (load_cnt_q != 4'd15));
		cmd.load_we   = in_valid && in_ready;
		cmd.load_addr = load_cnt_q;
		if (cmd.load_we) begin
			load_cnt_d = load_cnt_q + 4'd1;
		end

		cmd.cof_waddr    = idx_q;
		cmd.mc_sel       = det_mode_q ? m4i_pkg::MC_COF :
			((ph_q == 2'd2) ? m4i_pkg::MC_MINOR : m4i_pkg::MC_ELEM);
		cmd.mac_dest_acc = det_mode_q || (ph_q == 2'd2);
		cmd.mac_neg      = !det_mode_q && ((ph_q == 2'd1) ||
			((ph_q == 2'd2) && (term_q[0] ^ row[0] ^ col[0])));

		case (state_q)
			m4i_pkg::S_LOAD: begin
				if (in_valid && (load_cnt_q == 4'd15)) begin
					idx_d         = '0;
					term_d        = '0;
					ph_d          = '0;
					det_mode_d    = 1'b0;
					cmd.acc_clr   = 1'b1;
					cmd.minor_clr = 1'b1;
					state_d       = m4i_pkg::S_RD_A;
				end
			end
			m4i_pkg::S_RD_A: begin
				cmd.elem_raddr = mc_addr;
				cmd.cof_raddr  = idx_q;
				state_d        = m4i_pkg::S_RD_B;
			end
			m4i_pkg::S_RD_B: begin
				cmd.mc_load    = 1'b1;
				cmd.elem_raddr = mp_addr;
				state_d        = m4i_pkg::S_RD_C;
			end
			m4i_pkg::S_RD_C: begin
				cmd.mp_load = 1'b1;
				bit_d       = '0;
				state_d     = m4i_pkg::S_MAC;
			end
			m4i_pkg::S_MAC: begin
				cmd.mac_step = 1'b1;
				cmd.mac_last = mac_last;
				bit_d        = bit_q + CNT_W'(1);
				if (mac_last) begin
					if (det_mode_q) begin
						if (idx_q == 4'd3) begin
							state_d = m4i_pkg::S_DET;
						end else begin
							idx_d   = idx_q + 4'd1;
							state_d = m4i_pkg::S_RD_A;
						end
					end else if (ph_q != 2'd2) begin
						ph_d    = ph_q + 2'd1;
						state_d = m4i_pkg::S_RD_A;
					end else begin
						ph_d          = '0;
						cmd.minor_clr = 1'b1;
						if (term_q != 2'd2) begin
							term_d  = term_q + 2'd1;
							state_d = m4i_pkg::S_RD_A;
						end else begin
							term_d  = '0;
							state_d = m4i_pkg::S_COF_WR;
						end
					end
				end
			end
			m4i_pkg::S_COF_WR: begin
				cmd.cof_we  = 1'b1;
				cmd.acc_clr = 1'b1;
				state_d     = m4i_pkg::S_RD_A;
				if (idx_q == 4'd15) begin
					idx_d      = '0;
					det_mode_d = 1'b1;
				end else begin
					idx_d = idx_q + 4'd1;
				end
			end
			m4i_pkg::S_DET: begin
				cmd.det_load = 1'b1;
				idx_d        = '0;
				state_d      = m4i_pkg::S_DIV_RD;
			end
			m4i_pkg::S_DIV_RD: begin
				cmd.cof_raddr = src_addr;
				state_d       = m4i_pkg::S_DIV_INIT;
			end
			m4i_pkg::S_DIV_INIT: begin
				cmd.div_start = 1'b1;
				bit_d         = '0;
				state_d       = status.det_zero ? m4i_pkg::S_DIV_OUT : m4i_pkg::S_DIV;
			end
			m4i_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				bit_d        = bit_q + CNT_W'(1);
				if (div_last) begin
					state_d = m4i_pkg::S_DIV_OUT;
				end
			end
			m4i_pkg::S_DIV_OUT: begin
				if (!status.out_full) begin
					cmd.out_load = 1'b1;
					cmd.out_last = (idx_q == 4'd15);
					if (idx_q == 4'd15) begin
						state_d = m4i_pkg::S_LOAD;
					end else begin
						idx_d   = idx_q + 4'd1;
						state_d = m4i_pkg::S_DIV_RD;
					end
				end
			end
			default: begin
				state_d = m4i_pkg::S_LOAD;
			end
		endcase
	end
endmodule

// File: src/m4i_dp.sv
module m4i_dp #(
	parameter int W = m4i_pkg::DATA_WIDTH,
	parameter int F = m4i_pkg::FRAC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  m4i_pkg::cmd_t       cmd,
	output m4i_pkg::status_t    status,
	input  logic signed [W-1:0] element_value,
	input  logic                out_ready,
	output logic                out_valid,
	output logic signed [W-1:0] result_value,
	output logic                is_singular,
	output logic                is_last
);
	localparam int AW = 4 * W + 2;   // determinant range
	localparam int CW = 3 * W + 1;   // cofactor range
	localparam int NB = AW + 2 * F;  // dividend bits

	logic [W-1:0]  elem_rd;
	logic [CW-1:0] cof_rd;

	logic [AW-1:0] mc_q, minor_q, acc_q, dmag_q, addend;
	logic [W-1:0]  mp_q;
	logic          det_zero_q, det_neg_q;

	logic [NB-1:0] n_q;
	logic [AW:0]   rem_q, rs;
	logic [W-1:0]  q_q, lim, qsat, qval;
	logic          ovf_q, neg_q, ge;
	logic [CW-1:0] cof_mag;

	logic                res_valid_q, sing_q, last_q;
	logic signed [W-1:0] res_q;

	m4i_ram #(.WIDTH(W), .DEPTH(16)) u_elem_ram (
		.clk      (clk),
		.we       (cmd.load_we),
		.waddr    (cmd.load_addr),
		.wdata    (element_value),
		.raddr    (cmd.elem_raddr),
		.rd_data_q(elem_rd)
	);

	m4i_ram #(.WIDTH(CW), .DEPTH(16)) u_cof_ram (
		.clk      (clk),
		.we       (cmd.cof_we),
		.waddr    (cmd.cof_waddr),
		.wdata    (acc_q[CW-1:0]),
		.raddr    (cmd.cof_raddr),
		.rd_data_q(cof_rd)
	);

	// The multiplier's top bit weighs negative, so that step subtracts.
	always_comb begin
		if (!mp_q[0]) begin
			addend = '0;
		end else if (cmd.mac_neg ^ cmd.mac_last) begin
			addend = ~mc_q + AW'(1);
		end else begin
			addend = mc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mc_load) begin
			case (cmd.mc_sel)
				m4i_pkg::MC_ELEM:  mc_q <= {{(AW - W){elem_rd[W-1]}}, elem_rd};
				m4i_pkg::MC_MINOR: mc_q <= minor_q;
				m4i_pkg::MC_COF:   mc_q <= {{(AW - CW){cof_rd[CW-1]}}, cof_rd};
				default:           mc_q <= '0;
			endcase
		end else if (cmd.mac_step) begin
			mc_q <= {mc_q[AW-2:0], 1'b0};
		end

		if (cmd.mp_load) begin
			mp_q <= elem_rd;
		end else if (cmd.mac_step) begin
			mp_q <= {1'b0, mp_q[W-1:1]};
		end

		if (cmd.minor_clr) begin
			minor_q <= '0;
		end else if (cmd.mac_step && !cmd.mac_dest_acc) begin
			minor_q <= minor_q + addend;
		end

		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.mac_step && cmd.mac_dest_acc) begin
			acc_q <= acc_q + addend;
		end

		if (cmd.det_load) begin
			det_zero_q <= (acc_q == '0);
			det_neg_q  <= acc_q[AW-1];
			dmag_q     <= acc_q[AW-1] ? (~acc_q + AW'(1)) : acc_q;
		end
	end

	// Restoring division of |cofactor| * 2^(2F) by |determinant|, one bit a cycle.
	assign cof_mag = cof_rd[CW-1] ? (~cof_rd + CW'(1)) : cof_rd;
	assign rs      = {rem_q[AW-1:0], n_q[NB-1]};
	assign ge      = (rs >= {1'b0, dmag_q});

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			n_q   <= {{(AW - CW){1'b0}}, cof_mag, {(2 * F){1'b0}}};
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
			neg_q <= cof_rd[CW-1] ^ det_neg_q;
		end else if (cmd.div_step) begin
			n_q   <= {n_q[NB-2:0], 1'b0};
			rem_q <= ge ? (rs - {1'b0, dmag_q}) : rs;
			q_q   <= {q_q[W-2:0], ge};
			ovf_q <= ovf_q | q_q[W-1];
		end
	end

	always_comb begin
		lim  = neg_q ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
		qsat = (ovf_q || (q_q > lim)) ? lim : q_q;
		qval = neg_q ? (~qsat + W'(1)) : qsat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q  <= det_zero_q ? '0 : qval;
			sing_q <= det_zero_q;
			last_q <= cmd.out_last;
		end
	end

	assign status.det_zero = det_zero_q;
	assign status.out_full = res_valid_q && !out_ready;

	assign out_valid    = res_valid_q;
	assign result_value = res_q;
	assign is_singular  = sing_q;
	assign is_last      = last_q;
endmodule

// File: src/matrix4_inverse_unit.sv
// Sixteen elements load one a cycle while element.ready is high; nothing is emitted until the sixteenth.
// After it, the cofactors and then the determinant are computed,
// all on one shift-add multiply-accumulate unit; each result is then produced by a restoring divider.
// The next matrix loads during the divisions, all but its last element.
// arst_n clears the controller, the element counter, the output valid and emit_transposed.
module matrix4_inverse_unit #(
	parameter int DATA_WIDTH = m4i_pkg::DATA_WIDTH,
	parameter int FRAC_BITS  = m4i_pkg::FRAC_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	m4i_in_if.sink                           element,
	m4i_out_if.source                        result,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [m4i_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [m4i_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [m4i_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);
	m4i_pkg::cmd_t    cmd;
	m4i_pkg::status_t status;
	logic             emit_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= 1'b0;
		end else if (psel && penable && pwrite && (paddr[2] == m4i_pkg::REG_EMIT_TRANSPOSED)) begin
			emit_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == m4i_pkg::REG_EMIT_TRANSPOSED) ?
		{{(m4i_pkg::APB_DATA_W - 1){1'b0}}, emit_q} : '0;

	m4i_ctrl #(.W(DATA_WIDTH), .F(FRAC_BITS)) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (element.valid),
		.in_ready       (element.ready),
		.emit_transposed(emit_q),
		.status         (status),
		.cmd            (cmd)
	);

	m4i_dp #(.W(DATA_WIDTH), .F(FRAC_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.element_value(element.element_value),
		.out_ready    (result.ready),
		.out_valid    (result.valid),
		.result_value (result.result_value),
		.is_singular  (result.is_singular),
		.is_last      (result.is_last)
	);
endmodule
